// ===== hw/rtl/rme_pkg.sv =====
// Shared types and constants for the run-length mono bitmap expander.
// No dependencies; the CSR, front, FIFO, back and top-level files import this package.
`timescale 1ns / 1ps
`default_nettype none

package rme_pkg;

   // Stream escape code: next byte is a pattern, the one after is its count
   localparam logic [7:0] ESCAPE_BYTE = 8'h76;

   // Register file geometry
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register indexes (byte address is four times the index)
   typedef enum logic [2:0] {
      REG_FOREGROUND = 3'd0,
      REG_BACKGROUND = 3'd1,
      REG_ROW_BYTES  = 3'd2,
      REG_IMAGE_ROWS = 3'd3,
      REG_COMPRESSED = 3'd4
   } csr_reg_type;

   // Reset values of the registers
   localparam logic [15:0] FOREGROUND_RST = 16'hFFFF;
   localparam logic [15:0] BACKGROUND_RST = 16'h0000;
   localparam logic [5:0]  ROW_BYTES_RST  = 6'd40;
   localparam logic [8:0]  IMAGE_ROWS_RST = 9'd240;
   localparam logic        COMPRESSED_RST = 1'b1;

   // Depth of the run queue between front and back
   localparam int RUN_FIFO_DEPTH = 4;

   typedef struct packed {
      logic [15:0] foreground;
      logic [15:0] background;
      logic [5:0]  row_bytes;
      logic [8:0]  image_rows;
      logic        compressed;
   } cfg_type;

   // One run descriptor as it travels from front to back
   typedef struct packed {
      logic [7:0] pattern;
      logic [7:0] run_length;
      logic [8:0] row_index;
      logic [5:0] byte_column;
      logic       image_end;
   } run_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rme_if.sv =====
// Request and response channel interfaces of the bitmap expander.
// Depends on nothing; payload widths follow the stream and run formats.
`timescale 1ns / 1ps
`default_nettype none

// Stream bytes in
interface rme_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       image_start;

   modport source(output valid, output data_byte, output image_start, input ready);
   modport sink(input valid, input data_byte, input image_start, output ready);
endinterface

// Expanded runs out
interface rme_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_0;
   logic [15:0] pixel_1;
   logic [15:0] pixel_2;
   logic [15:0] pixel_3;
   logic [15:0] pixel_4;
   logic [15:0] pixel_5;
   logic [15:0] pixel_6;
   logic [15:0] pixel_7;
   logic [7:0]  run_length;
   logic [8:0]  row_index;
   logic [5:0]  byte_column;
   logic        image_end;

   modport source(output valid, output pixel_0, output pixel_1, output pixel_2,
                  output pixel_3, output pixel_4, output pixel_5, output pixel_6,
                  output pixel_7, output run_length, output row_index,
                  output byte_column, output image_end, input ready);
   modport sink(input valid, input pixel_0, input pixel_1, input pixel_2,
                input pixel_3, input pixel_4, input pixel_5, input pixel_6,
                input pixel_7, input run_length, input row_index,
                input byte_column, input image_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rme_csr.sv =====
// Configuration register file with an APB-style write/read port.
// Depends on rme_pkg for register indexes, reset values and cfg_type.
`timescale 1ns / 1ps
`default_nettype none

module rme_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [rme_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [rme_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [rme_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready,
   output rme_pkg::cfg_type                    cfg
);
   import rme_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_reg_type reg_sel;
   logic        wr_en;

   assign pready  = 1'b1;
   assign reg_sel = csr_reg_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en   = psel & penable & pwrite & pready;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_FOREGROUND: cfg_in.foreground = pwdata[15:0];
            REG_BACKGROUND: cfg_in.background = pwdata[15:0];
            REG_ROW_BYTES:  cfg_in.row_bytes  = pwdata[5:0];
            REG_IMAGE_ROWS: cfg_in.image_rows = pwdata[8:0];
            REG_COMPRESSED: cfg_in.compressed = pwdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.foreground <= FOREGROUND_RST;
         cfg_ff.background <= BACKGROUND_RST;
         cfg_ff.row_bytes  <= ROW_BYTES_RST;
         cfg_ff.image_rows <= IMAGE_ROWS_RST;
         cfg_ff.compressed <= COMPRESSED_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      prdata = '0;
      case (reg_sel)
         REG_FOREGROUND: prdata[15:0] = cfg_ff.foreground;
         REG_BACKGROUND: prdata[15:0] = cfg_ff.background;
         REG_ROW_BYTES:  prdata[5:0]  = cfg_ff.row_bytes;
         REG_IMAGE_ROWS: prdata[8:0]  = cfg_ff.image_rows;
         REG_COMPRESSED: prdata[0]    = cfg_ff.compressed;
         default:        prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rme_front.sv =====
// Front end: accepts stream bytes, tracks escape state and row/column,
// and emits clipped run descriptors. Depends on rme_pkg and rme_req_if.
`timescale 1ns / 1ps
`default_nettype none

module rme_front #(
   parameter int MAX_LINE_PIXELS = 320
) (
   input  wire logic             clock,
   input  wire logic             reset,
   rme_req_if.sink               req,
   input  wire rme_pkg::cfg_type cfg,
   input  wire logic             run_full,
   output logic                  run_push,
   output rme_pkg::run_type      run
);
   import rme_pkg::*;

   // Row width cap from the line buffer size, clipped to the 6-bit register range
   localparam int          CapBytes = MAX_LINE_PIXELS / 8;
   localparam int          CapClip  = (CapBytes > 63) ? 63 : CapBytes;
   localparam logic [5:0]  CapLimit = 6'(CapClip);

   typedef enum logic [1:0] {
      ESC_NORMAL  = 2'd0,
      ESC_PATTERN = 2'd1,
      ESC_COUNT   = 2'd2
   } esc_type;

   esc_type    esc_ff, esc_in;
   logic [7:0] held_ff, held_in;
   logic [8:0] row_ff, row_in;
   logic [5:0] col_ff, col_in;
   logic       done_ff, done_in;

   logic       accept;
   logic [5:0] lim;
   logic [5:0] left;
   logic [7:0] pat;
   logic [7:0] cnt;
   logic       emit;
   logic [6:0] col_sum;

   assign req.ready = ~run_full;
   assign accept    = req.valid & req.ready;

   // Effective row width: at least one byte, at most the line buffer
   always_comb begin
      lim = (cfg.row_bytes == 6'd0) ? 6'd1 : cfg.row_bytes;
      if (lim > CapLimit) begin
         lim = CapLimit;
      end
   end

   // Per-byte state update and run build
   always_comb begin
      esc_in   = esc_ff;
      held_in  = held_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      done_in  = done_ff;
      run_push = 1'b0;
      run      = '0;
      pat      = '0;
      cnt      = '0;
      emit     = 1'b0;
      left     = '0;
      col_sum  = '0;
      if (accept) begin
         if (req.image_start) begin
            row_in  = '0;
            col_in  = '0;
            esc_in  = ESC_NORMAL;
            done_in = 1'b0;
         end
         if (!(done_in || row_in >= cfg.image_rows)) begin
            // row already full (width lowered): move on before the byte
            if (col_in >= lim) begin
               col_in = '0;
               row_in = 9'(row_in + 9'd1);
               if (row_in >= cfg.image_rows) begin
                  done_in = 1'b1;
               end
            end
            if (!done_in) begin
               if (!cfg.compressed) begin
                  esc_in = ESC_NORMAL;
                  pat    = req.data_byte;
                  cnt    = 8'd1;
                  emit   = 1'b1;
               end else begin
                  case (esc_in)
                     ESC_PATTERN: begin
                        held_in = req.data_byte;
                        esc_in  = ESC_COUNT;
                     end
                     ESC_COUNT: begin
                        esc_in = ESC_NORMAL;
                        pat    = held_in;
                        cnt    = req.data_byte;
                        emit   = 1'b1;
                     end
                     default: begin
                        if (req.data_byte == ESCAPE_BYTE) begin
                           esc_in = ESC_PATTERN;
                        end else begin
                           esc_in = ESC_NORMAL;
                           pat    = req.data_byte;
                           cnt    = 8'd1;
                           emit   = 1'b1;
                        end
                     end
                  endcase
               end
               if (emit && cnt != 8'd0) begin
                  // clip at row end
                  left = lim - col_in;
                  if (cnt > {2'b00, left}) begin
                     cnt = {2'b00, left};
                  end
                  run.pattern     = pat;
                  run.run_length  = cnt;
                  run.row_index   = row_in;
                  run.byte_column = col_in;
                  col_sum = {1'b0, col_in} + {1'b0, cnt[5:0]};
                  col_in  = col_sum[5:0];
                  if (col_sum >= {1'b0, lim}) begin
                     col_in = '0;
                     row_in = 9'(row_in + 9'd1);
                     if (row_in >= cfg.image_rows) begin
                        done_in = 1'b1;
                     end
                     run.image_end = done_in;
                  end
                  run_push = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff  <= ESC_NORMAL;
         held_ff <= '0;
         row_ff  <= '0;
         col_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         esc_ff  <= esc_in;
         held_ff <= held_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         done_ff <= done_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rme_fifo.sv =====
// Short run descriptor queue between the front and back ends.
// Depends on rme_pkg for run_type and the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module rme_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire rme_pkg::run_type push_run,
   output logic                  full,
   input  wire logic             pop,
   output rme_pkg::run_type      pop_run,
   output logic                  empty
);
   import rme_pkg::*;

   localparam int PtrW = $clog2(RUN_FIFO_DEPTH);
   localparam int CntW = $clog2(RUN_FIFO_DEPTH + 1);

   run_type         mem [RUN_FIFO_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full    = (count_ff == CntW'(RUN_FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign pop_run = mem[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? PtrW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? PtrW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = CntW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CntW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_run;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rme_back.sv =====
// Back end: pops run descriptors, expands the pattern MSB first into
// eight colors and holds the response register. Depends on rme_pkg, rme_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module rme_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rme_pkg::cfg_type cfg,
   input  wire logic             run_empty,
   input  wire rme_pkg::run_type run,
   output logic                  run_pop,
   rme_rsp_if.source             rsp
);
   import rme_pkg::*;

   logic        out_valid_ff, out_valid_in;
   logic [15:0] pix_ff [8];
   logic [15:0] pix_in [8];
   logic [7:0]  len_ff;
   logic [8:0]  row_ff;
   logic [5:0]  col_ff;
   logic        end_ff;

   // Take a new run when the response register is free or draining
   assign run_pop      = ~run_empty & (~out_valid_ff | rsp.ready);
   assign out_valid_in = run_pop | (out_valid_ff & ~rsp.ready);

   // Bit expansion: pixel k follows pattern bit 7-k
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         pix_in[k] = run.pattern[7-k] ? cfg.foreground : cfg.background;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload register, loaded on pop
   always_ff @(posedge clock) begin
      if (run_pop) begin
         for (int k = 0; k < 8; k++) begin
            pix_ff[k] <= pix_in[k];
         end
         len_ff <= run.run_length;
         row_ff <= run.row_index;
         col_ff <= run.byte_column;
         end_ff <= run.image_end;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.pixel_0     = pix_ff[0];
   assign rsp.pixel_1     = pix_ff[1];
   assign rsp.pixel_2     = pix_ff[2];
   assign rsp.pixel_3     = pix_ff[3];
   assign rsp.pixel_4     = pix_ff[4];
   assign rsp.pixel_5     = pix_ff[5];
   assign rsp.pixel_6     = pix_ff[6];
   assign rsp.pixel_7     = pix_ff[7];
   assign rsp.run_length  = len_ff;
   assign rsp.row_index   = row_ff;
   assign rsp.byte_column = col_ff;
   assign rsp.image_end   = end_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rle_mono_bitmap_expander.sv =====
// Top level of the run-length mono bitmap expander.
// Depends on rme_pkg, rme_if, rme_csr, rme_front, rme_fifo and rme_back.
//
//   Port group  Direction  Handshake             Carries
//   req_ch      in         valid/ready           data_byte, image_start
//   rsp_ch      out        valid/ready           pixel_0..7, run_length, row, column, end
//   p*          in/out     psel/penable/pready   register writes and reads
//
// One stream byte is accepted every cycle while the run queue has room.
// A run goes from its last byte into the queue and from there into the response
// register, which drives rsp_ch.
// Reset (synchronous) restores the configuration registers, empties the queue and clears position and escape state.
// A stalled rsp_ch fills the four-entry queue, then req_ch.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module rle_mono_bitmap_expander #(
   parameter int MAX_LINE_PIXELS = 320
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   rme_req_if.sink                             req_ch,
   rme_rsp_if.source                           rsp_ch,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [rme_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [rme_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [rme_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready
);
   import rme_pkg::*;

   cfg_type cfg;
   run_type push_run;
   run_type pop_run;
   logic    run_push;
   logic    run_full;
   logic    run_pop;
   logic    run_empty;

   rme_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rme_front #(
      .MAX_LINE_PIXELS (MAX_LINE_PIXELS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .cfg      (cfg),
      .run_full (run_full),
      .run_push (run_push),
      .run      (push_run)
   );

   rme_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (run_push),
      .push_run (push_run),
      .full     (run_full),
      .pop      (run_pop),
      .pop_run  (pop_run),
      .empty    (run_empty)
   );

   rme_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .run_empty (run_empty),
      .run       (pop_run),
      .run_pop   (run_pop),
      .rsp       (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/rme_checker.sv =====
// Port-level checks for the bitmap expander, bound to the top level.
// Depends only on the top level's port names.
`timescale 1ns / 1ps
`default_nettype none

module rme_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_run_length,
   input wire logic [5:0] rsp_byte_column,
   input wire logic [8:0] rsp_row_index
);

   // No response can be pending right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A run always covers at least one byte
   a_nonzero_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_run_length != 8'd0)
      else $error("zero-length run delivered");

   // A run never extends past the end of the widest possible row (63 bytes)
   a_row_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({3'b000, rsp_byte_column} + {1'b0, rsp_run_length}) <= 9'd63)
      else $error("run extends past the widest row");

   // Stalled response stays valid and holds its length, row and column
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_run_length)
         && $stable(rsp_row_index) && $stable(rsp_byte_column))
      else $error("stalled response changed");

endmodule

bind rle_mono_bitmap_expander rme_checker u_rme_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_run_length  (rsp_ch.run_length),
   .rsp_byte_column (rsp_ch.byte_column),
   .rsp_row_index   (rsp_ch.row_index)
);

`default_nettype wire
